// File: rtl/gta_pkg.sv
package gta_pkg;

  localparam int DEF_TILE_COUNT = 128;
  localparam int WORD_BITS      = 32;
  localparam int BIT_SEL_W      = 5;
  localparam int WORD_SEL_W     = 3;
  localparam int CHAR_W         = 8;
  localparam int TILE_W         = 8;
  localparam int TILE_OUT_W     = 7;
  localparam int CHAR_COUNT     = 256;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [TILE_W-1:0] tile;
  } lookup_t;

  typedef struct packed {
    logic              found;
    logic [TILE_W-1:0] tile;
  } pick_t;

  // Tiles of word w that belong to the pool.
  function automatic logic [WORD_BITS-1:0] pool_mask(input int w, input int tile_count);
    int first;
    int count;
    first = w * WORD_BITS;
    if (first >= tile_count) begin
      return '0;
    end
    count = tile_count - first;
    if (count >= WORD_BITS) begin
      return '1;
    end
    return (WORD_BITS'(1) << count) - WORD_BITS'(1);
  endfunction

  // Word 0 holds the reserved tile 0.
  function automatic logic [WORD_BITS-1:0] reset_word(input int w);
    return (w == 0) ? WORD_BITS'(1) : '0;
  endfunction

endpackage

// File: rtl/gta_char_map.sv
module gta_char_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [gta_pkg::CHAR_W-1:0]  rd_addr,
  output gta_pkg::lookup_t            lookup,
  input  logic                        wr_en,
  input  logic [gta_pkg::CHAR_W-1:0]  wr_addr,
  input  logic [gta_pkg::TILE_W-1:0]  wr_tile
);

  logic [gta_pkg::TILE_W-1:0]     map_mem [gta_pkg::CHAR_COUNT];
  logic [gta_pkg::CHAR_COUNT-1:0] valid_r;
  logic                           rd_valid_r;
  logic [gta_pkg::TILE_W-1:0]     rd_tile_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_tile;
    end
    if (rd_en) begin
      rd_tile_r <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign lookup.hit  = rd_valid_r;
  assign lookup.tile = rd_tile_r;

endmodule

// File: rtl/gta_tile_pool.sv
module gta_tile_pool #(
  parameter int TILE_COUNT = gta_pkg::DEF_TILE_COUNT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          alloc_en,
  output gta_pkg::pick_t pick
);

  localparam int NWORDS = (TILE_COUNT + gta_pkg::WORD_BITS - 1) / gta_pkg::WORD_BITS;
  localparam int WIDX   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = $clog2(NWORDS + 1);

  logic [gta_pkg::WORD_BITS-1:0] word_mem [NWORDS];
  logic [NWORDS-1:0]             word_ok_r;
  logic [CW-1:0]                 cur_word_r;
  logic [CW-1:0]                 cur_word_nxt;
  logic [gta_pkg::WORD_BITS-1:0] rd_raw_r;
  logic                          rd_ok_r;
  logic [WIDX-1:0]               word_idx;
  logic                          exhausted;
  logic [gta_pkg::WORD_BITS-1:0] mask;
  logic [gta_pkg::WORD_BITS-1:0] word;
  logic [gta_pkg::WORD_BITS-1:0] free_bits;
  logic [gta_pkg::WORD_BITS-1:0] new_word;
  logic [gta_pkg::BIT_SEL_W-1:0] bit_sel;

  assign word_idx  = cur_word_r[WIDX-1:0];
  assign exhausted = (cur_word_r == CW'(NWORDS));
  assign mask      = gta_pkg::pool_mask(int'(cur_word_r), TILE_COUNT);
  assign word      = rd_ok_r ? rd_raw_r : gta_pkg::reset_word(int'(cur_word_r));
  assign free_bits = ~word & mask;

  always_comb begin
    bit_sel = '0;
    for (int i = 0; i < gta_pkg::WORD_BITS; i++) begin
      if (free_bits[i]) begin
        bit_sel = gta_pkg::BIT_SEL_W'(i);
      end
    end
  end

  assign new_word   = word | (gta_pkg::WORD_BITS'(1) << bit_sel);
  assign pick.found = !exhausted && (free_bits != '0);
  assign pick.tile  = {gta_pkg::WORD_SEL_W'(cur_word_r), bit_sel};

  // Bits are only ever set, so the first word with a free tile only moves up.
  always_comb begin
    cur_word_nxt = cur_word_r;
    if (alloc_en && pick.found && ((new_word | ~mask) == '1)) begin
      cur_word_nxt = cur_word_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_en && pick.found) begin
      word_mem[word_idx] <= new_word;
    end
    if (rd_en && !exhausted) begin
      rd_raw_r <= word_mem[word_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_ok_r  <= '0;
      cur_word_r <= '0;
      rd_ok_r    <= 1'b0;
    end else begin
      cur_word_r <= cur_word_nxt;
      if (alloc_en && pick.found) begin
        word_ok_r[word_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= !exhausted && word_ok_r[word_idx];
      end
    end
  end

endmodule

// File: rtl/glyph_tile_allocator_top.sv
// Glyph tile allocator: assigns a display tile to each character code.
// Request channel: drive in_char_code and raise start; the request is taken
// at a rising edge where start is high and busy is low.
// Result channel: out_strobe is high for exactly one cycle with out_tile_index,
// out_newly_assigned and out_pool_full; the receiver cannot stall it.
// The request is read from the character map and tile pool when it is taken,
// and out_strobe is registered from the update state that follows.
// A new request is not taken while busy is high in that update state, in which
// the character map and the in-use bitmap are written back.
// A mapped character returns its tile. An unmapped one gets the highest free
// tile of the lowest word of the in-use bitmap that still has one, with
// out_newly_assigned set. With no free tile, tile 0 is used and out_pool_full
// is set as well. Tiles are never released.
// Reset is synchronous and active low. Afterwards no character is mapped and
// only tile 0 is in use; valid bits clear the memories at once, so requests
// are taken from the first cycle after reset.
module glyph_tile_allocator_top #(
  parameter int TILE_COUNT = gta_pkg::DEF_TILE_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [gta_pkg::CHAR_W-1:0]      in_char_code,
  output logic                            out_strobe,
  output logic [gta_pkg::TILE_OUT_W-1:0]  out_tile_index,
  output logic                            out_newly_assigned,
  output logic                            out_pool_full
);

  gta_pkg::state_t            state_r;
  gta_pkg::state_t            state_nxt;
  gta_pkg::lookup_t           lookup;
  gta_pkg::pick_t             pick;
  logic [gta_pkg::CHAR_W-1:0] char_r;
  logic                       accept;
  logic                       update;
  logic                       miss;
  logic [gta_pkg::TILE_W-1:0] tile;
  logic                       strobe_r;
  logic [gta_pkg::TILE_OUT_W-1:0] tile_r;
  logic                       fresh_r;
  logic                       full_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gta_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = gta_pkg::ST_UPDATE;
        end
      end
      gta_pkg::ST_UPDATE: begin
        state_nxt = gta_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gta_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    update = 1'b0;
    case (state_r)
      gta_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      gta_pkg::ST_UPDATE: begin
        busy   = 1'b1;
        update = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;
  assign miss   = update && !lookup.hit;
  assign tile   = lookup.hit ? lookup.tile : (pick.found ? pick.tile : '0);

  gta_char_map u_char_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_char_code),
    .lookup  (lookup),
    .wr_en   (miss),
    .wr_addr (char_r),
    .wr_tile (tile)
  );

  gta_tile_pool #(
    .TILE_COUNT (TILE_COUNT)
  ) u_tile_pool (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .alloc_en (miss),
    .pick     (pick)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_char_code;
    end
    if (update) begin
      tile_r  <= tile[gta_pkg::TILE_OUT_W-1:0];
      fresh_r <= !lookup.hit;
      full_r  <= !lookup.hit && !pick.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gta_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= update;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_tile_index     = tile_r;
  assign out_newly_assigned = fresh_r;
  assign out_pool_full      = full_r;

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding update cycle");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not enter the update cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("update lasted more than one cycle");

  a_full_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pool_full) |-> out_newly_assigned)
    else $error("pool full reported for a mapped character");

  a_full_tile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pool_full) |-> (out_tile_index == '0))
    else $error("pool full reported with a tile other than zero");

endmodule
